@@ rtl/wso_pkg.sv @@
// wso_pkg: shared types and constants of the wheel speed / odometer core
// no dependencies; imported by every module of the block
`default_nettype none

package wso_pkg;

	// field and accumulator widths
	localparam int ACC_W    = 48;
	localparam int SPD_W    = 16;
	localparam int CIRC_W   = 12;
	localparam int PER_W    = 32;
	localparam int FAC_W    = 9;
	localparam int ROT_W    = 16;
	localparam int REQ_W    = 2;

	// shared multiplier operands and product
	localparam int MUL_A_W  = 24;
	localparam int MUL_B_W  = 20;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

	// divider: numerator up to distance * 921600, divisor up to the trip time
	localparam int NUM_W    = 72;
	localparam int DEN_W    = ACC_W;
	localparam int CNT_W    = $clog2(NUM_W);

	// apb register map
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 2;

	localparam logic [IDX_W-1:0] REG_CIRC   = 2'd0;
	localparam logic [IDX_W-1:0] REG_MIN    = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX    = 2'd2;
	localparam logic [IDX_W-1:0] REG_FACTOR = 2'd3;

	localparam logic [CIRC_W-1:0] CIRC_RST   = 12'd2100;
	localparam logic [PER_W-1:0]  MIN_RST    = 32'd50000;
	localparam logic [PER_W-1:0]  MAX_RST    = 32'd4000000;
	localparam logic [FAC_W-1:0]  FACTOR_RST = 9'd77;

	// request codes
	localparam logic [REQ_W-1:0] REQ_WHEEL  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PERIOD = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TRIP   = 2'd2;

	// 3600 s/h * 256 for q8.8 km/h from mm/us
	localparam logic [MUL_B_W-1:0] SCALE_Q8  = 20'd921600;
	localparam logic [SPD_W-1:0]   SPEED_MAX = '1;
	localparam logic [ACC_W-1:0]   ACC_MAX   = '1;
	localparam logic [FAC_W-1:0]   FACTOR_ONE = 9'd256;

	typedef struct packed {
		logic [CIRC_W-1:0] circ;
		logic [PER_W-1:0]  min_period;
		logic [PER_W-1:0]  max_period;
		logic [FAC_W-1:0]  factor;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SPD_W-1:0] quot;
	} div_res_t;

endpackage

`default_nettype wire

@@ rtl/wso_cfg.sv @@
// wso_cfg: apb register file holding circumference, period limits and smoothing factor
// depends on wso_pkg
`default_nettype none

module wso_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [wso_pkg::ADDR_W-1:0] paddr,
	input  wire logic [wso_pkg::DATA_W-1:0] pwdata,
	output logic      [wso_pkg::DATA_W-1:0] prdata,
	output logic                           pready,
	output wso_pkg::cfg_t                  cfg
);
	import wso_pkg::*;

	cfg_t            cfg_q;
	logic            wr_en;
	logic [IDX_W-1:0] idx;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.circ       <= CIRC_RST;
			cfg_q.min_period <= MIN_RST;
			cfg_q.max_period <= MAX_RST;
			cfg_q.factor     <= FACTOR_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_CIRC:   cfg_q.circ       <= pwdata[CIRC_W-1:0];
				REG_MIN:    cfg_q.min_period <= pwdata[PER_W-1:0];
				REG_MAX:    cfg_q.max_period <= pwdata[PER_W-1:0];
				REG_FACTOR: cfg_q.factor     <= pwdata[FAC_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CIRC:   prdata = DATA_W'(cfg_q.circ);
			REG_MIN:    prdata = DATA_W'(cfg_q.min_period);
			REG_MAX:    prdata = DATA_W'(cfg_q.max_period);
			REG_FACTOR: prdata = DATA_W'(cfg_q.factor);
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/wso_div.sv @@
// wso_div: restoring divider, one quotient bit per cycle, rounded and saturated to 16 bits
// depends on wso_pkg
`default_nettype none

module wso_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wso_pkg::div_req_t req,
	output wso_pkg::div_res_t      res
);
	import wso_pkg::*;

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [SPD_W-1:0] quot_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic             rnd;
	logic [SPD_W:0]   q_rnd;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quot_q <= {quot_q[SPD_W-2:0], ge};
			// a one shifted out of the top means the quotient is past full scale
			ovf_q  <= ovf_q | quot_q[SPD_W-1];
		end else if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end
	end

	// round half up: twice the remainder against the divisor
	assign rnd   = {rem_q, 1'b0} >= {1'b0, den_q};
	assign q_rnd = {1'b0, quot_q} + (SPD_W + 1)'(rnd);

	assign res.done = done_q;
	assign res.quot = (ovf_q || q_rnd[SPD_W]) ? SPEED_MAX : q_rnd[SPD_W-1:0];

endmodule

`default_nettype wire

@@ rtl/wheel_speed_odometer_core.sv @@
// a wheel update or rejected sample makes one divider pass (average speed), an accepted
// period sample two (current speed, then average); a zero trip time, as after a trip reset,
// skips the average pass
// one item at a time, in_ready high only while idle; a result not yet taken holds the next
// reset clears distances, trip time, speed, the output valid flag and restores register defaults
// depends on wso_pkg, wso_cfg, wso_div
`default_nettype none

module wheel_speed_odometer_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wso_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [wso_pkg::DATA_W-1:0]  pwdata,
	output logic      [wso_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [wso_pkg::REQ_W-1:0]   req_type,
	input  wire logic [wso_pkg::ROT_W-1:0]   rot_count,
	input  wire logic [wso_pkg::PER_W-1:0]   time_delta_us,
	input  wire logic [wso_pkg::PER_W-1:0]   rot_period,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [wso_pkg::ACC_W-1:0]   trip_len,
	output logic      [wso_pkg::ACC_W-1:0]   trip_elapsed,
	output logic      [wso_pkg::ACC_W-1:0]   odo_len,
	output logic      [wso_pkg::SPD_W-1:0]   current_speed,
	output logic      [wso_pkg::SPD_W-1:0]   average_speed,
	output logic                             moving
);
	import wso_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
	localparam logic [ST_W-1:0] S_UPD      = 4'd1;
	localparam logic [ST_W-1:0] S_ACC      = 4'd2;
	localparam logic [ST_W-1:0] S_SPD_GO   = 4'd3;
	localparam logic [ST_W-1:0] S_SPD_WAIT = 4'd4;
	localparam logic [ST_W-1:0] S_BL0      = 4'd5;
	localparam logic [ST_W-1:0] S_BL1      = 4'd6;
	localparam logic [ST_W-1:0] S_BL2      = 4'd7;
	localparam logic [ST_W-1:0] S_AVG0     = 4'd8;
	localparam logic [ST_W-1:0] S_AVG1     = 4'd9;
	localparam logic [ST_W-1:0] S_AVG2     = 4'd10;
	localparam logic [ST_W-1:0] S_AVG_WAIT = 4'd11;
	localparam logic [ST_W-1:0] S_OUT      = 4'd12;

	cfg_t     cfg;
	div_req_t div_req;
	div_res_t div_res;

	logic [ST_W-1:0]    state_q;

	// architectural state
	logic [ACC_W-1:0]   trip_dist_q;
	logic [ACC_W-1:0]   trip_time_q;
	logic [ACC_W-1:0]   total_dist_q;
	logic [SPD_W-1:0]   speed_q;
	logic               speed_valid_q;

	// item and working registers
	logic [REQ_W-1:0]   req_q;
	logic [ROT_W-1:0]   rot_q;
	logic [PER_W-1:0]   dt_q;
	logic [PER_W-1:0]   period_q;
	logic [SPD_W-1:0]   spd_new_q;
	logic [SPD_W-1:0]   avg_q;
	logic [23:0]        bl_acc_q;
	logic [MUL_P_W-1:0] hi_q;
	logic [MUL_P_W-1:0] mul_q;

	logic               out_valid_q;
	logic [ACC_W-1:0]   out_trip_dist_q;
	logic [ACC_W-1:0]   out_trip_time_q;
	logic [ACC_W-1:0]   out_total_q;
	logic [SPD_W-1:0]   out_speed_q;
	logic [SPD_W-1:0]   out_avg_q;
	logic               out_moving_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [FAC_W-1:0]   f_eff;
	logic [FAC_W-1:0]   f_inv;
	logic [ACC_W:0]     trip_dist_sum;
	logic [ACC_W:0]     total_sum;
	logic [ACC_W:0]     trip_time_sum;
	logic [24:0]        bl_sum;
	logic [NUM_W-1:0]   avg_num;
	logic               in_range;
	logic               in_take;
	logic               out_load;

	wso_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wso_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_take  = in_valid & in_ready;
	assign out_load = (state_q == S_OUT) & (~out_valid_q | out_ready);

	assign f_eff = cfg.factor[FAC_W-1] ? FACTOR_ONE : cfg.factor;
	assign f_inv = FACTOR_ONE - f_eff;

	assign in_range = (period_q >= cfg.min_period) && (period_q <= cfg.max_period);

	assign trip_dist_sum = {1'b0, trip_dist_q} + (ACC_W + 1)'(mul_q[27:0]);
	assign total_sum     = {1'b0, total_dist_q} + (ACC_W + 1)'(mul_q[27:0]);
	assign trip_time_sum = {1'b0, trip_time_q} + (ACC_W + 1)'(dt_q);

	assign bl_sum  = {1'b0, bl_acc_q} + {1'b0, mul_q[23:0]} + 25'd128;
	assign avg_num = NUM_W'({hi_q, 24'd0}) + NUM_W'(mul_q);

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_UPD: begin
				if (req_q == REQ_PERIOD) begin
					mul_a = MUL_A_W'(cfg.circ);
					mul_b = SCALE_Q8;
				end else begin
					mul_a = MUL_A_W'(rot_q);
					mul_b = MUL_B_W'(cfg.circ);
				end
			end
			S_BL0: begin
				mul_a = MUL_A_W'(spd_new_q);
				mul_b = MUL_B_W'(f_eff);
			end
			S_BL1: begin
				mul_a = MUL_A_W'(speed_q);
				mul_b = MUL_B_W'(f_inv);
			end
			S_AVG0: begin
				mul_a = trip_dist_q[ACC_W-1:24];
				mul_b = SCALE_Q8;
			end
			S_AVG1: begin
				mul_a = trip_dist_q[23:0];
				mul_b = SCALE_Q8;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_req.start = (state_q == S_SPD_GO) || (state_q == S_AVG2);
		div_req.num   = (state_q == S_AVG2) ? avg_num : NUM_W'(mul_q[PER_W-1:0]);
		div_req.den   = (state_q == S_AVG2) ? trip_time_q : DEN_W'(period_q);
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (in_take) begin
			req_q    <= req_type;
			rot_q    <= rot_count;
			dt_q     <= time_delta_us;
			period_q <= rot_period;
		end
		if (state_q == S_UPD)
			spd_new_q <= SPEED_MAX;
		else if (state_q == S_SPD_WAIT && div_res.done)
			spd_new_q <= div_res.quot;
		if (state_q == S_BL1)
			bl_acc_q <= mul_q[23:0];
		if (state_q == S_AVG1)
			hi_q <= mul_q;
		if (state_q == S_AVG0)
			avg_q <= '0;
		else if (state_q == S_AVG_WAIT && div_res.done)
			avg_q <= div_res.quot;
		if (out_load) begin
			out_trip_dist_q <= trip_dist_q;
			out_trip_time_q <= trip_time_q;
			out_total_q     <= total_dist_q;
			out_speed_q     <= speed_q;
			out_avg_q       <= avg_q;
			out_moving_q    <= speed_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			trip_dist_q   <= '0;
			trip_time_q   <= '0;
			total_dist_q  <= '0;
			speed_q       <= '0;
			speed_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_take)
						state_q <= S_UPD;
				end
				S_UPD: begin
					unique case (req_q)
						REQ_WHEEL:  state_q <= S_ACC;
						REQ_PERIOD: begin
							if (!in_range)
								state_q <= S_AVG0;
							else if (period_q == '0)
								state_q <= S_BL0;
							else
								state_q <= S_SPD_GO;
						end
						REQ_TRIP: begin
							trip_dist_q   <= '0;
							trip_time_q   <= '0;
							speed_q       <= '0;
							speed_valid_q <= 1'b0;
							state_q       <= S_AVG0;
						end
						default: state_q <= S_AVG0;
					endcase
				end
				S_ACC: begin
					trip_dist_q  <= trip_dist_sum[ACC_W] ? ACC_MAX : trip_dist_sum[ACC_W-1:0];
					total_dist_q <= total_sum[ACC_W] ? ACC_MAX : total_sum[ACC_W-1:0];
					trip_time_q  <= trip_time_sum[ACC_W] ? ACC_MAX : trip_time_sum[ACC_W-1:0];
					state_q      <= S_AVG0;
				end
				S_SPD_GO: state_q <= S_SPD_WAIT;
				S_SPD_WAIT: begin
					if (div_res.done)
						state_q <= S_BL0;
				end
				S_BL0: begin
					// first sample since reset or a trip reset seeds the speed
					if (!speed_valid_q) begin
						speed_q       <= spd_new_q;
						speed_valid_q <= 1'b1;
						state_q       <= S_AVG0;
					end else begin
						state_q <= S_BL1;
					end
				end
				S_BL1: state_q <= S_BL2;
				S_BL2: begin
					speed_q <= bl_sum[23:8];
					state_q <= S_AVG0;
				end
				S_AVG0: begin
					if (trip_time_q == '0)
						state_q <= S_OUT;
					else
						state_q <= S_AVG1;
				end
				S_AVG1: state_q <= S_AVG2;
				S_AVG2: state_q <= S_AVG_WAIT;
				S_AVG_WAIT: begin
					if (div_res.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign trip_len      = out_trip_dist_q;
	assign trip_elapsed  = out_trip_time_q;
	assign odo_len       = out_total_q;
	assign current_speed = out_speed_q;
	assign average_speed = out_avg_q;
	assign moving        = out_moving_q;

endmodule

`default_nettype wire
